// ===== hw/rtl/xkb_pkg.sv =====
// Package for the repeating-key XOR base64 encoder: widths, register
// indexes, the word type between encoder and character buffer, and the
// base64 alphabet. No dependencies.
`timescale 1ns / 1ps

package xkb_pkg;

  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int POS_W     = 3;
  localparam int LEN_W     = 4;
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 4;
  localparam int MAX_CHARS = 4;
  localparam int CIDX_W    = 2;

  // Register index, taken from paddr[3] (registers sit on 8-byte strides).
  localparam logic REG_KEY_BYTES  = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // One to four characters produced by a single message byte.
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [CIDX_W-1:0]         last_idx;
    logic                      eom;
  } burst_t;

  // Map a 6-bit group to its standard base64 character.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    priority if (v < 6'd26) begin
      c = 8'h41 + w;
    end else if (v < 6'd52) begin
      c = 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/xkb_ifs.sv =====
// Channel interfaces of the encoder: message bytes in, characters out.
// Uses nothing but plain logic signals.
`timescale 1ns / 1ps

interface xkb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  modport source(output valid, data_byte, end_of_message, input ready);
  modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

interface xkb_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  modport source(output valid, text_char, last_char, input ready);
  modport sink(input valid, text_char, last_char, output ready);
endinterface

// ===== hw/rtl/xkb_cfg_regs.sv =====
// APB-style register file holding the key and its length, plus the
// clamped key length used by the encoder. Depends on xkb_pkg.
`timescale 1ns / 1ps

module xkb_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [xkb_pkg::ADDR_W-1:0]  paddr,
  input  logic [xkb_pkg::DATA_W-1:0]  pwdata,
  output logic [xkb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [xkb_pkg::KEY_W-1:0]   key_bytes,
  output logic [xkb_pkg::LEN_W-1:0]   active_len
);

  logic [xkb_pkg::LEN_W-1:0] key_length;
  logic                      wr_en;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes  <= '0;
      key_length <= xkb_pkg::LEN_W'(1);
    end else if (wr_en) begin
      unique case (reg_sel)
        xkb_pkg::REG_KEY_BYTES:  key_bytes  <= pwdata[xkb_pkg::KEY_W-1:0];
        xkb_pkg::REG_KEY_LENGTH: key_length <= pwdata[xkb_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      xkb_pkg::REG_KEY_BYTES:  prdata = xkb_pkg::DATA_W'(key_bytes);
      xkb_pkg::REG_KEY_LENGTH: prdata = xkb_pkg::DATA_W'(key_length);
      default:                 prdata = '0;
    endcase
  end

  // A zero length counts as one; anything beyond the key store saturates.
  always_comb begin
    priority if (key_length == '0) begin
      active_len = xkb_pkg::LEN_W'(1);
    end else if (key_length > xkb_pkg::LEN_W'(xkb_pkg::KEY_BYTES)) begin
      active_len = xkb_pkg::LEN_W'(xkb_pkg::KEY_BYTES);
    end else begin
      active_len = key_length;
    end
  end

endmodule

// ===== hw/rtl/xkb_encoder.sv =====
// Input register, key/group state and the XOR plus base64 logic that turns
// one byte into a word of one to four characters. Depends on xkb_pkg, xkb_ifs.
`timescale 1ns / 1ps

module xkb_encoder (
  input  logic                       clk,
  input  logic                       rst,
  xkb_byte_if.sink                   msg,
  input  logic [xkb_pkg::KEY_W-1:0]  key_bytes,
  input  logic [xkb_pkg::LEN_W-1:0]  active_len,
  output logic                       burst_valid,
  input  logic                       burst_ready,
  output xkb_pkg::burst_t            burst
);

  logic                      in_valid;
  logic [7:0]                in_byte;
  logic                      in_eom;
  logic [xkb_pkg::POS_W-1:0] key_position;
  logic [1:0]                group_phase;
  logic [3:0]                leftover_bits;

  logic [xkb_pkg::POS_W-1:0] key_position_next;
  logic [1:0]                group_phase_next;
  logic [3:0]                leftover_bits_next;

  logic                      take;
  logic [7:0]                key_byte;
  logic [7:0]                x;
  logic [xkb_pkg::LEN_W-1:0] pos_inc;
  logic [1:0]                step_phase;
  logic [3:0]                step_left;
  logic [xkb_pkg::POS_W-1:0] step_pos;

  assign take        = in_valid && burst_ready;
  assign msg.ready   = !in_valid || take;
  assign burst_valid = in_valid;

  assign key_byte = key_bytes[{key_position, 3'b000} +: 8];
  assign x        = in_byte ^ key_byte;
  assign pos_inc  = xkb_pkg::LEN_W'(key_position) + xkb_pkg::LEN_W'(1);
  assign step_pos = (pos_inc >= active_len) ? '0 : pos_inc[xkb_pkg::POS_W-1:0];

  always_comb begin
    burst.chars = '0;
    burst.eom   = in_eom;
    unique case (group_phase)
      2'd1: begin
        burst.chars[0] = xkb_pkg::b64_char({leftover_bits[1:0], x[7:4]});
        burst.last_idx = 2'd0;
        step_left      = x[3:0];
        step_phase     = 2'd2;
      end
      2'd2: begin
        burst.chars[0] = xkb_pkg::b64_char({leftover_bits, x[7:6]});
        burst.chars[1] = xkb_pkg::b64_char(x[5:0]);
        burst.last_idx = 2'd1;
        step_left      = 4'd0;
        step_phase     = 2'd0;
      end
      default: begin
        burst.chars[0] = xkb_pkg::b64_char(x[7:2]);
        burst.last_idx = 2'd0;
        step_left      = {2'b00, x[1:0]};
        step_phase     = 2'd1;
      end
    endcase

    // On the final byte, flush the partial character and pad the group.
    if (in_eom) begin
      unique case (step_phase)
        2'd1: begin
          burst.chars[1] = xkb_pkg::b64_char({step_left[1:0], 4'b0000});
          burst.chars[2] = xkb_pkg::PAD_CHAR;
          burst.chars[3] = xkb_pkg::PAD_CHAR;
          burst.last_idx = 2'd3;
        end
        2'd2: begin
          burst.chars[1] = xkb_pkg::b64_char({step_left, 2'b00});
          burst.chars[2] = xkb_pkg::PAD_CHAR;
          burst.last_idx = 2'd2;
        end
        default: ;
      endcase
      key_position_next  = '0;
      group_phase_next   = 2'd0;
      leftover_bits_next = 4'd0;
    end else begin
      key_position_next  = step_pos;
      group_phase_next   = step_phase;
      leftover_bits_next = step_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      key_position  <= '0;
      group_phase   <= 2'd0;
      leftover_bits <= 4'd0;
    end else begin
      if (msg.ready) begin
        in_valid <= msg.valid;
      end
      if (take) begin
        key_position  <= key_position_next;
        group_phase   <= group_phase_next;
        leftover_bits <= leftover_bits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      in_byte <= msg.data_byte;
      in_eom  <= msg.end_of_message;
    end
  end

endmodule

// ===== hw/rtl/xkb_char_out.sv =====
// Result register: holds one word of characters and hands them out one per
// cycle while the output channel is ready. Depends on xkb_pkg, xkb_ifs.
`timescale 1ns / 1ps

module xkb_char_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              burst_valid,
  output logic              burst_ready,
  input  xkb_pkg::burst_t   burst,
  xkb_char_if.source        text
);

  logic                       buf_valid;
  xkb_pkg::burst_t            held;
  logic [xkb_pkg::CIDX_W-1:0] idx;
  logic                       at_last;
  logic                       load;

  assign at_last     = (idx == held.last_idx);
  assign burst_ready = !buf_valid || (text.ready && at_last);
  assign load        = burst_valid && burst_ready;

  assign text.valid     = buf_valid;
  assign text.text_char = held.chars[idx];
  assign text.last_char = held.eom && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      buf_valid <= 1'b1;
      idx       <= '0;
    end else if (buf_valid && text.ready) begin
      if (at_last) begin
        buf_valid <= 1'b0;
      end else begin
        idx <= idx + xkb_pkg::CIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= burst;
    end
  end

endmodule

// ===== hw/rtl/xor_key_base64_encoder.sv =====
// Repeating-key XOR base64 encoder, top level. Depends on xkb_pkg, xkb_ifs,
// xkb_cfg_regs, xkb_encoder and xkb_char_out.
// Path: an accepted byte passes the input register, then the character buffer,
// before its first character shows. Throughput: one character per cycle while
// the output is ready; a byte yields one or two characters, up to four on the last.
// Reset (rst, synchronous): key 0, key length 1, key position and phase zero.
`timescale 1ns / 1ps

module xor_key_base64_encoder (
  input  logic                        clk,
  input  logic                        rst,
  xkb_byte_if.sink                    msg,
  xkb_char_if.source                  text,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [xkb_pkg::ADDR_W-1:0]  paddr,
  input  logic [xkb_pkg::DATA_W-1:0]  pwdata,
  output logic [xkb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // Configuration: the key sits at byte address 0, its length at address 8.
  // The encoder sees the length already clamped to one through the key size.
  logic [xkb_pkg::KEY_W-1:0] key_bytes;
  logic [xkb_pkg::LEN_W-1:0] active_len;

  // A word here is the group of one to four characters that one message
  // byte produces, passed from the encoder to the character buffer.
  logic            burst_valid;
  logic            burst_ready;
  xkb_pkg::burst_t burst;

  xkb_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_bytes  (key_bytes),
    .active_len (active_len)
  );

  // The encoder registers the incoming byte, then XORs it with the key byte
  // at the current position and cuts the result into base64 characters. Its
  // key position, group phase and leftover bits advance only when the word
  // moves on to the character buffer, so a stalled output freezes the state.
  xkb_encoder u_enc (
    .clk         (clk),
    .rst         (rst),
    .msg         (msg),
    .key_bytes   (key_bytes),
    .active_len  (active_len),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  // The character buffer refills in the same cycle as its last character
  // leaves, so the output channel can stream without gaps while the input
  // register already holds the next byte.
  xkb_char_out u_out (
    .clk         (clk),
    .rst         (rst),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst),
    .text        (text)
  );

endmodule
